// ----- hw/rtl/sid_pkg.sv -----
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the sensor ID table and health tracker.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UNK_W   = $clog2(SLOTS + 1);

    localparam logic [7:0]  ERROR_CAP_RESET   = 8'd100;
    localparam logic [10:0] GRACE_LIMIT_RESET = 11'd1440;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_TICK   = 2'd1,
        OP_ENROLL = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    localparam logic CFG_ERROR_CAP   = 1'b0;
    localparam logic CFG_GRACE_LIMIT = 1'b1;

    typedef struct packed {
        logic [7:0]         id;
        logic               valid;
        logic signed [15:0] temperature;
        logic [7:0]         humidity;
        logic               battery;
        logic               updated;
        logic [7:0]         errors;
        logic [10:0]        grace;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef struct packed {
        logic [7:0]  error_cap;
        logic [10:0] grace_limit;
    } tick_cfg_t;

endpackage

// ----- hw/rtl/sid_ram.sv -----
// ----------------------------------------------------------------------------
// sid_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/sid_slot_ager.sv -----
// ----------------------------------------------------------------------------
// sid_slot_ager
// Minute-tick aging of one slot entry: error count and grace counter update.
// ----------------------------------------------------------------------------
module sid_slot_ager (
    input  sid_pkg::tick_cfg_t   cfg,
    input  sid_pkg::slot_entry_t entry_in,
    output sid_pkg::slot_entry_t entry_out,
    output logic                 failing
);
    import sid_pkg::*;

    logic [10:0] grace_inc;

    assign grace_inc = entry_in.grace + 11'd1;

    always_comb
    begin
        entry_out = entry_in;
        if (entry_in.valid)
        begin
            if (!entry_in.updated)
            begin
                entry_out.grace = '0;
                if (entry_in.errors < cfg.error_cap)
                begin
                    entry_out.errors = entry_in.errors + 8'd1;
                end
            end
            else
            begin
                entry_out.grace = grace_inc;
                if (grace_inc >= cfg.grace_limit)
                begin
                    entry_out.grace = '0;
                    if (entry_in.errors != 8'd0)
                    begin
                        entry_out.errors = entry_in.errors - 8'd1;
                    end
                end
            end
            entry_out.updated = 1'b0;
        end
    end

    // A slot counts as failing once aging leaves it valid with errors.
    assign failing = entry_out.valid && (entry_out.errors != 8'd0);

endmodule

// ----- hw/rtl/sensor_id_table_health_tracker_core.sv -----
// ----------------------------------------------------------------------------
// sensor_id_table_health_tracker_core
// Sensor slot table with packet matching, unknown-ID list and tick aging.
// ----------------------------------------------------------------------------
// Flow: a read or an enroll presents the slot address, then reads or writes
// the row; a packet searches the slots, then the unknown IDs, and appends an
// ID found in neither; a tick ages every slot, then may replace one failing ID.
// One item is handled at a time; the input is ready only while idle.
// Reset clears all control state and marks every slot row unwritten, so
// rows read as zero at once; no clearing pass is needed.
module sensor_id_table_health_tracker_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [10:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [7:0]          sensor_id,
    input  logic signed [15:0]  temperature,
    input  logic [7:0]          humidity,
    input  logic                battery_low,
    input  logic [2:0]          slot,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                slot_valid,
    output logic [7:0]          slot_id,
    output logic signed [15:0]  slot_temperature,
    output logic [7:0]          slot_humidity,
    output logic                slot_battery_low,
    output logic [7:0]          slot_errors,
    output logic                slot_updated,
    output logic                hit,
    output logic                replaced,
    output logic [3:0]          unknown_count
);
    import sid_pkg::*;

    // The sequencer walks the slot RAM one entry at a time: an issue state
    // presents the address, the following state sees the registered data and,
    // where it changes the entry, writes the modified entry back.
    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_PKT_RD  = 15'b000000000000010,
        S_PKT_CHK = 15'b000000000000100,
        S_UNK_RD  = 15'b000000000001000,
        S_UNK_CHK = 15'b000000000010000,
        S_UNK_APP = 15'b000000000100000,
        S_TICK_RD = 15'b000000001000000,
        S_TICK_CHK= 15'b000000010000000,
        S_FIX_RD  = 15'b000000100000000,
        S_FIX_WR  = 15'b000001000000000,
        S_ENR_RD  = 15'b000010000000000,
        S_ENR_WR  = 15'b000100000000000,
        S_RD_RD   = 15'b001000000000000,
        S_RD_CHK  = 15'b010000000000000,
        S_FIN     = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    tick_cfg_t cfg_reg;

    // Latched input item.
    op_t                op_reg;
    logic [7:0]         id_reg;
    logic signed [15:0] temp_reg;
    logic [7:0]         hum_reg;
    logic               bat_reg;
    logic [2:0]         slot_reg;

    logic [SLOT_IW-1:0] sidx_reg, sidx_next;
    logic [SLOT_IW-1:0] uidx_reg, uidx_next;
    logic [UNK_W-1:0]   unk_total_reg, unk_total_next;
    logic [1:0]         fail_cnt_reg, fail_cnt_next;
    logic [SLOT_IW-1:0] fail_slot_reg, fail_slot_next;

    // Result being built, and the output register that holds it.
    slot_entry_t res_entry_reg, res_entry_next;
    logic        res_hit_reg, res_hit_next;
    logic        res_repl_reg, res_repl_next;

    logic        out_valid_reg;
    slot_entry_t out_entry_reg;
    logic        out_hit_reg;
    logic        out_repl_reg;
    logic [3:0]  out_cnt_reg;

    // Slot RAM with one written-row flag per entry; an unwritten row reads
    // as all zero, which is its reset value.
    logic [SLOTS-1:0]   row_live_reg;
    logic               rd_live_reg;
    logic               sram_we;
    logic [SLOT_IW-1:0] sram_waddr;
    slot_entry_t        sram_wdata;
    logic [SLOT_IW-1:0] sram_raddr;
    logic [ENTRY_W-1:0] sram_q;
    slot_entry_t        rd_entry;

    // Unknown ID RAM; only entries below the count are ever read.
    logic               uram_we;
    logic [SLOT_IW-1:0] uram_waddr;
    logic [SLOT_IW-1:0] uram_raddr;
    logic [7:0]         uram_q;

    slot_entry_t aged_entry;
    logic        aged_failing;

    logic        sidx_last;
    logic        slot_in_range;
    logic        accept;
    logic        deliver;

    sid_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .raddr (sram_raddr),
        .rdata (sram_q)
    );

    sid_ram #(
        .WIDTH (8),
        .DEPTH (SLOTS)
    ) u_unknown_ram (
        .clk   (clk),
        .we    (uram_we),
        .waddr (uram_waddr),
        .wdata (id_reg),
        .raddr (uram_raddr),
        .rdata (uram_q)
    );

    sid_slot_ager u_ager (
        .cfg       (cfg_reg),
        .entry_in  (rd_entry),
        .entry_out (aged_entry),
        .failing   (aged_failing)
    );

    assign rd_entry      = rd_live_reg ? slot_entry_t'(sram_q) : '0;
    assign sidx_last     = (sidx_reg == SLOT_IW'(SLOTS - 1));
    assign slot_in_range = (32'(slot_reg) < SLOTS);
    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    // The finished result moves to the output register once it is free.
    assign deliver       = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        sidx_next      = sidx_reg;
        uidx_next      = uidx_reg;
        unk_total_next = unk_total_reg;
        fail_cnt_next  = fail_cnt_reg;
        fail_slot_next = fail_slot_reg;
        res_entry_next = res_entry_reg;
        res_hit_next   = res_hit_reg;
        res_repl_next  = res_repl_reg;
        sram_we        = 1'b0;
        sram_waddr     = sidx_reg;
        sram_wdata     = rd_entry;
        sram_raddr     = sidx_reg;
        uram_we        = 1'b0;
        uram_waddr     = unk_total_reg[SLOT_IW-1:0];
        uram_raddr     = uidx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sidx_next      = '0;
                    uidx_next      = '0;
                    fail_cnt_next  = '0;
                    res_entry_next = '0;
                    res_hit_next   = 1'b0;
                    res_repl_next  = 1'b0;
                    unique case (op_t'(op))
                        OP_PACKET: state_next = S_PKT_RD;
                        OP_TICK:   state_next = S_TICK_RD;
                        OP_ENROLL: state_next = S_ENR_RD;
                        OP_READ:   state_next = S_RD_RD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_PKT_RD:
            begin
                state_next = S_PKT_CHK;
            end
            S_PKT_CHK:
            begin
                if (rd_entry.id == id_reg)
                begin
                    sram_we                = 1'b1;
                    sram_wdata.temperature = temp_reg;
                    sram_wdata.humidity    = hum_reg;
                    sram_wdata.battery     = bat_reg;
                    sram_wdata.updated     = 1'b1;
                    res_hit_next           = 1'b1;
                    state_next             = S_FIN;
                end
                else if (!sidx_last)
                begin
                    sidx_next  = sidx_reg + SLOT_IW'(1);
                    state_next = S_PKT_RD;
                end
                else if (unk_total_reg == '0)
                begin
                    state_next = S_UNK_APP;
                end
                else
                begin
                    state_next = S_UNK_RD;
                end
            end
            S_UNK_RD:
            begin
                state_next = S_UNK_CHK;
            end
            S_UNK_CHK:
            begin
                if (uram_q == id_reg)
                begin
                    state_next = S_FIN;
                end
                else if ((UNK_W'(uidx_reg) + UNK_W'(1)) == unk_total_reg)
                begin
                    state_next = S_UNK_APP;
                end
                else
                begin
                    uidx_next  = uidx_reg + SLOT_IW'(1);
                    state_next = S_UNK_RD;
                end
            end
            S_UNK_APP:
            begin
                if (32'(unk_total_reg) < SLOTS)
                begin
                    uram_we        = 1'b1;
                    unk_total_next = unk_total_reg + UNK_W'(1);
                end
                state_next = S_FIN;
            end
            S_TICK_RD:
            begin
                state_next = S_TICK_CHK;
            end
            S_TICK_CHK:
            begin
                sram_we    = 1'b1;
                sram_wdata = aged_entry;
                if (aged_failing)
                begin
                    fail_slot_next = sidx_reg;
                    if (fail_cnt_reg != 2'd2)
                    begin
                        fail_cnt_next = fail_cnt_reg + 2'd1;
                    end
                end
                if (!sidx_last)
                begin
                    sidx_next  = sidx_reg + SLOT_IW'(1);
                    state_next = S_TICK_RD;
                end
                else if ((fail_cnt_next == 2'd1) && (unk_total_reg == UNK_W'(1)))
                begin
                    state_next = S_FIX_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIX_RD:
            begin
                sram_raddr = fail_slot_reg;
                uram_raddr = '0;
                state_next = S_FIX_WR;
            end
            S_FIX_WR:
            begin
                sram_we       = 1'b1;
                sram_waddr    = fail_slot_reg;
                sram_wdata.id = uram_q;
                res_repl_next = 1'b1;
                state_next    = S_FIN;
            end
            S_ENR_RD:
            begin
                sram_raddr = SLOT_IW'(slot_reg);
                state_next = S_ENR_WR;
            end
            S_ENR_WR:
            begin
                sram_we          = slot_in_range;
                sram_waddr       = SLOT_IW'(slot_reg);
                sram_wdata.id    = id_reg;
                sram_wdata.valid = 1'b1;
                state_next       = S_FIN;
            end
            S_RD_RD:
            begin
                sram_raddr = SLOT_IW'(slot_reg);
                state_next = S_RD_CHK;
            end
            S_RD_CHK:
            begin
                if (slot_in_range)
                begin
                    res_entry_next       = rd_entry;
                    res_entry_next.grace = '0;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (deliver)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= '{error_cap: ERROR_CAP_RESET, grace_limit: GRACE_LIMIT_RESET};
            unk_total_reg <= '0;
            row_live_reg  <= '0;
            rd_live_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            sidx_reg      <= '0;
            uidx_reg      <= '0;
            fail_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            unk_total_reg <= unk_total_next;
            sidx_reg      <= sidx_next;
            uidx_reg      <= uidx_next;
            fail_cnt_reg  <= fail_cnt_next;
            rd_live_reg   <= row_live_reg[sram_raddr];
            if (sram_we)
            begin
                row_live_reg[sram_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ERROR_CAP:   cfg_reg.error_cap   <= cfg_data[7:0];
                    CFG_GRACE_LIMIT: cfg_reg.grace_limit <= cfg_data;
                    default:         cfg_reg             <= cfg_reg;
                endcase
            end
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        fail_slot_reg <= fail_slot_next;
        res_entry_reg <= res_entry_next;
        res_hit_reg   <= res_hit_next;
        res_repl_reg  <= res_repl_next;
        if (accept)
        begin
            op_reg   <= op_t'(op);
            id_reg   <= sensor_id;
            temp_reg <= temperature;
            hum_reg  <= humidity;
            bat_reg  <= battery_low;
            slot_reg <= slot;
        end
        if (deliver)
        begin
            out_entry_reg <= res_entry_reg;
            out_hit_reg   <= res_hit_reg;
            out_repl_reg  <= res_repl_reg;
            out_cnt_reg   <= 4'(unk_total_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign slot_valid       = out_entry_reg.valid;
    assign slot_id          = out_entry_reg.id;
    assign slot_temperature = out_entry_reg.temperature;
    assign slot_humidity    = out_entry_reg.humidity;
    assign slot_battery_low = out_entry_reg.battery;
    assign slot_errors      = out_entry_reg.errors;
    assign slot_updated     = out_entry_reg.updated;
    assign hit              = out_hit_reg;
    assign replaced         = out_repl_reg;
    assign unknown_count    = out_cnt_reg;

    // The unknown list never holds more IDs than it has entries.
    a_unk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(unk_total_reg) <= SLOTS)
        else $error("unknown ID count exceeds list depth");

    // A packet hit and a tick replacement are never reported together.
    a_hit_repl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_repl_reg))
        else $error("hit and replaced both set");

    // A transfer in always starts work, so the input stays closed next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input ready right after a transfer");

    // A replacement only follows a tick with a single unknown ID.
    a_fix_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX_WR) |-> (unk_total_reg == UNK_W'(1) && op_reg == OP_TICK))
        else $error("replacement without a single unknown ID");

endmodule
